// File: src/lal_pkg.sv
// ----------------------------------------------------------------------------
// lal_pkg: shared types and constants for the Scheme atom lexer
// Lexer states, token kinds, error codes and the fixnum overflow thresholds.
// ----------------------------------------------------------------------------
package lal_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COMMENT, ST_SIGN, ST_FIX, ST_HASH, ST_BOOL, ST_CHAR0,
    ST_CHAR1, ST_NAME, ST_STR, ST_ESC, ST_CONT1, ST_CONT2
  } lex_state_e;

  typedef enum logic [2:0] {
    K_FIX, K_BOOL, K_CHAR, K_SCHAR, K_SEND, K_ERR, K_END
  } tok_kind_e;

  typedef enum logic [2:0] {
    E_BAD_START, E_FIX_DELIM, E_BAD_BOOL, E_BAD_CHAR, E_CHAR_END,
    E_SPACE_CHAR, E_BAD_ESC, E_STR_END
  } err_code_e;

  // Lexer context carried from byte to byte
  typedef struct packed {
    lex_state_e  st;
    logic [63:0] acc;
    logic        neg;
    logic [7:0]  held;
    logic [2:0]  nsel;
    logic [2:0]  npos;
    logic        sat;
  } lex_ctx_t;

  // One result token
  typedef struct packed {
    tok_kind_e   kind;
    logic [63:0] value;
    err_code_e   err;
    logic        ovf;
  } tok_t;

  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  // Largest magnitude that still takes digit d without passing the limit
  localparam logic [63:0] THR_POS [10] = '{
    (LIM_POS - 64'd0) / 64'd10, (LIM_POS - 64'd1) / 64'd10,
    (LIM_POS - 64'd2) / 64'd10, (LIM_POS - 64'd3) / 64'd10,
    (LIM_POS - 64'd4) / 64'd10, (LIM_POS - 64'd5) / 64'd10,
    (LIM_POS - 64'd6) / 64'd10, (LIM_POS - 64'd7) / 64'd10,
    (LIM_POS - 64'd8) / 64'd10, (LIM_POS - 64'd9) / 64'd10
  };
  localparam logic [63:0] THR_NEG [10] = '{
    (LIM_NEG - 64'd0) / 64'd10, (LIM_NEG - 64'd1) / 64'd10,
    (LIM_NEG - 64'd2) / 64'd10, (LIM_NEG - 64'd3) / 64'd10,
    (LIM_NEG - 64'd4) / 64'd10, (LIM_NEG - 64'd5) / 64'd10,
    (LIM_NEG - 64'd6) / 64'd10, (LIM_NEG - 64'd7) / 64'd10,
    (LIM_NEG - 64'd8) / 64'd10, (LIM_NEG - 64'd9) / 64'd10
  };

  localparam logic [7:0] CH_SEMI = 8'h3B;

endpackage

// File: src/lisp_atom_lexer_core.sv
// ----------------------------------------------------------------------------
// lisp_atom_lexer_core: streaming tokenizer for Scheme literals
// One source byte per request in, tokens out through a four-entry queue.
// ----------------------------------------------------------------------------
// Each accepted byte is lexed in the cycle it is taken: the lexer context is
// updated at that edge and the zero to two tokens it causes are written into
// a four-entry result queue. A byte can be taken every cycle while the queue
// holds two or fewer tokens, so throughput is one byte per cycle unless the
// token consumer stalls or bytes average more than one token each; the queue
// drains one token per cycle. Byte value 0xFF is ordinary data; only tlast
// marks end of input, and after it the lexer is idle again.
module lisp_atom_lexer_core
  import lal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] token_value, [66:64] error_code,
                                      // [67] overflow, [71:68] zero
  output logic [2:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast    // last_in_run
);

  // --------------------------------------------------------------------------
  // Character classes and name tables
  // --------------------------------------------------------------------------
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_delim(input logic [7:0] b, input logic eoi);
    return eoi || is_space(b) || b == "(" || b == ")" || b == "\"" || b == CH_SEMI;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [3:0] name_len(input logic [2:0] s);
    case (s)
      3'd1:    return 4'd7;
      3'd2:    return 4'd3;
      3'd3:    return 4'd8;
      3'd4:    return 4'd6;
      3'd5:    return 4'd5;
      default: return 4'd3;
    endcase
  endfunction

  function automatic logic [7:0] name_val(input logic [2:0] s);
    case (s)
      3'd1:    return 8'd10;
      3'd2:    return 8'd9;
      3'd3:    return 8'd10;
      3'd4:    return 8'd13;
      3'd5:    return 8'd32;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_chr(input logic [2:0] s, input logic [2:0] i);
    logic [63:0] txt;
    case (s)
      3'd1:    txt = "newline";
      3'd2:    txt = "tab";
      3'd3:    txt = "linefeed";
      3'd4:    txt = "return";
      3'd5:    txt = "space";
      default: txt = "nul";
    endcase
    // left-align the text so index 0 is the first letter
    txt = txt << (8 * (8 - name_len(s)));
    return txt[8*(7 - i) +: 8];
  endfunction

  function automatic logic [3:0] pick_name(input logic [7:0] c, input logic [7:0] a);
    if (c == "n" && a == "u") return 4'd0;
    if (c == "n" && a == "e") return 4'd1;
    if (c == "t" && a == "a") return 4'd2;
    if (c == "l" && a == "i") return 4'd3;
    if (c == "r" && a == "e") return 4'd4;
    if (c == "s" && a == "p") return 4'd5;
    return 4'd8;
  endfunction

  function automatic logic [8:0] esc_val(input logic [7:0] e);
    case (e)
      "a":     return 9'd7;
      "b":     return 9'd8;
      "t":     return 9'd9;
      "n":     return 9'd10;
      "v":     return 9'd11;
      "f":     return 9'd12;
      "r":     return 9'd13;
      "\"":    return 9'h022;
      "\\":    return 9'h05C;
      default: return 9'h100;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // One lexer pass over a byte; again means the byte is handled once more
  // --------------------------------------------------------------------------
  function automatic void lex_pass(
    input  lex_ctx_t   s,
    input  logic [7:0] b,
    input  logic       eoi,
    output lex_ctx_t   n,
    output logic       emit,
    output tok_t       t,
    output logic       again
  );
    logic [63:0] bv;
    logic [63:0] b64;
    logic [3:0]  d;
    logic [63:0] thr;
    logic [3:0]  k;
    logic [3:0]  len;
    logic [2:0]  pos;
    logic [2:0]  idx;
    logic [8:0]  ev;
    n     = s;
    emit  = 1'b0;
    again = 1'b0;
    t     = '{kind: K_END, value: 64'd0, err: E_BAD_START, ovf: 1'b0};
    b64   = {56'd0, b};
    bv    = eoi ? 64'd0 : b64;
    d     = 4'(b - "0");
    thr   = s.neg ? THR_NEG[d] : THR_POS[d];
    k     = pick_name(s.held, b);
    len   = name_len(s.nsel);
    pos   = (4'(s.npos) > len - 4'd2) ? 3'(len - 4'd2) : s.npos;
    idx   = 3'(len - 4'(pos));
    ev    = esc_val(b);
    case (s.st)
      ST_IDLE: begin
        if (eoi) begin
          emit = 1'b1;
          t.kind = K_END;
        end else if (is_space(b)) begin
        end else if (b == CH_SEMI) begin
          n.st = ST_COMMENT;
        end else if (is_digit(b)) begin
          n.neg = 1'b0; n.acc = {60'd0, d}; n.sat = 1'b0; n.st = ST_FIX;
        end else if (b == "+" || b == "-") begin
          n.held = b; n.st = ST_SIGN;
        end else if (b == "#") begin
          n.st = ST_HASH;
        end else if (b == "\"") begin
          n.st = ST_STR;
        end else begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_START; t.value = b64;
        end
      end
      ST_COMMENT: begin
        if (eoi) begin
          n.st = ST_IDLE; again = 1'b1;
        end else if (b == 8'h0A) begin
          n.st = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (!eoi && is_digit(b)) begin
          n.neg = (s.held == "-"); n.acc = {60'd0, d}; n.sat = 1'b0; n.st = ST_FIX;
        end else begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_START; t.value = {56'd0, s.held};
          n.st = ST_IDLE; again = 1'b1;
        end
      end
      ST_FIX: begin
        if (!eoi && is_digit(b)) begin
          if (s.acc > thr) begin
            n.acc = s.neg ? LIM_NEG : LIM_POS; n.sat = 1'b1;
          end else begin
            n.acc = {s.acc[60:0], 3'b0} + {s.acc[62:0], 1'b0} + {60'd0, d};
          end
        end else begin
          emit = 1'b1;
          if (is_delim(b, eoi)) begin
            t.kind = K_FIX; t.value = s.neg ? (64'd0 - s.acc) : s.acc; t.ovf = s.sat;
          end else begin
            t.kind = K_ERR; t.err = E_FIX_DELIM; t.value = b64;
          end
          n.st = ST_IDLE; again = 1'b1;
        end
      end
      ST_HASH: begin
        if (!eoi && b == "\\") begin
          n.st = ST_CHAR0;
        end else if (!eoi && (b == "t" || b == "f")) begin
          n.held = b; n.st = ST_BOOL;
        end else begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_BOOL; t.value = bv;
          n.st = ST_IDLE; again = eoi;
        end
      end
      ST_BOOL: begin
        emit = 1'b1;
        if (is_delim(b, eoi)) begin
          t.kind = K_BOOL; t.value = {63'd0, s.held == "t"};
        end else begin
          t.kind = K_ERR; t.err = E_BAD_BOOL; t.value = b64;
        end
        n.st = ST_IDLE; again = 1'b1;
      end
      ST_CHAR0: begin
        if (eoi) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_CHAR_END;
          n.st = ST_IDLE; again = 1'b1;
        end else if (is_space(b)) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_SPACE_CHAR; t.value = b64;
          n.st = ST_IDLE;
        end else begin
          n.held = b; n.st = ST_CHAR1;
        end
      end
      ST_CHAR1: begin
        if (is_delim(b, eoi)) begin
          emit = 1'b1; t.kind = K_CHAR; t.value = {56'd0, s.held};
          n.st = ST_IDLE; again = 1'b1;
        end else if (!k[3]) begin
          n.nsel = k[2:0]; n.npos = 3'(name_len(k[2:0]) - 4'd2); n.st = ST_NAME;
        end else begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_CHAR; t.value = b64;
          n.st = ST_IDLE; again = 1'b1;
        end
      end
      ST_NAME: begin
        n.npos = pos;
        if (pos != 3'd0 && !eoi && b == name_chr(s.nsel, idx)) begin
          n.npos = pos - 3'd1;
        end else begin
          emit = 1'b1;
          if (pos == 3'd0 && is_delim(b, eoi)) begin
            t.kind = K_CHAR; t.value = {56'd0, name_val(s.nsel)};
          end else begin
            t.kind = K_ERR; t.err = E_BAD_CHAR; t.value = bv;
          end
          n.st = ST_IDLE; again = 1'b1;
        end
      end
      ST_STR: begin
        if (eoi) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_STR_END;
          n.st = ST_IDLE; again = 1'b1;
        end else if (b == "\"") begin
          emit = 1'b1; t.kind = K_SEND; n.st = ST_IDLE;
        end else if (b == "\\") begin
          n.st = ST_ESC;
        end else begin
          emit = 1'b1; t.kind = K_SCHAR; t.value = b64;
        end
      end
      ST_ESC: begin
        if (eoi) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_ESC;
          n.st = ST_IDLE; again = 1'b1;
        end else if (!ev[8]) begin
          emit = 1'b1; t.kind = K_SCHAR; t.value = {56'd0, ev[7:0]}; n.st = ST_STR;
        end else if (b == 8'h0A) begin
          n.st = ST_CONT2;
        end else if (is_space(b)) begin
          n.st = ST_CONT1;
        end else begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_ESC; t.value = b64;
          n.st = ST_IDLE;
        end
      end
      ST_CONT1: begin
        if (eoi) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_ESC;
          n.st = ST_IDLE; again = 1'b1;
        end else if (b == 8'h0A) begin
          n.st = ST_CONT2;
        end else if (!is_space(b)) begin
          emit = 1'b1; t.kind = K_ERR; t.err = E_BAD_ESC; t.value = b64;
          n.st = ST_IDLE;
        end
      end
      ST_CONT2: begin
        if (eoi || !is_space(b) || b == 8'h0A) begin
          n.st = ST_STR; again = 1'b1;
        end
      end
      default: begin
        n.st = ST_IDLE; again = 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Lexer context and per-byte evaluation (at most three passes per byte;
  // the third is only reached from a line continuation at end of input)
  // --------------------------------------------------------------------------
  lex_ctx_t ctx_q, ctx_d;
  lex_ctx_t ctx_mid, ctx_end, ctx_fin;
  logic     em1, em2, em3, ag1, ag2, ag3, emit2, emit3;
  tok_t     tk1, tk2, tk3;
  logic     in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    lex_pass(ctx_q, s_axis_tdata, s_axis_tlast, ctx_mid, em1, tk1, ag1);
    lex_pass(ctx_mid, s_axis_tdata, s_axis_tlast, ctx_end, em2, tk2, ag2);
    lex_pass(ctx_end, s_axis_tdata, s_axis_tlast, ctx_fin, em3, tk3, ag3);
    emit2 = ag1 && em2;
    emit3 = ag1 && ag2 && em3;
    ctx_d = !ag1 ? ctx_mid : (!ag2 ? ctx_end : ctx_fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '{st: ST_IDLE, acc: 64'd0, neg: 1'b0, held: 8'd0,
                 nsel: 3'd0, npos: 3'd0, sat: 1'b0};
    end else if (in_fire) begin
      ctx_q <= ctx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two tokens in and, while the consumer is ready, one out per cycle
  // --------------------------------------------------------------------------
  tok_t       q_tok_q  [4];
  logic       q_last_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic [1:0] push_n;
  logic       pop;
  tok_t       w0_tok;
  tok_t       w1_tok;
  logic       w0_last;

  // first pass and third pass never both emit, so a byte pushes at most two
  assign s_axis_tready = (cnt_q <= 3'd2);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = in_fire ? (2'(em1) + 2'(emit2) + 2'(emit3)) : 2'd0;
  assign w0_tok        = em1 ? tk1 : (emit2 ? tk2 : tk3);
  assign w1_tok        = emit3 ? tk3 : tk2;
  assign w0_last       = (push_n != 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_tok_q[wr_ptr_q]  <= w0_tok;
      q_last_q[wr_ptr_q] <= w0_last;
    end
    if (push_n == 2'd2) begin
      q_tok_q[wr_ptr_q + 2'd1]  <= w1_tok;
      q_last_q[wr_ptr_q + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      cnt_q    <= cnt_q + 3'(push_n) - 3'(pop);
    end
  end

  // Output mapping
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = q_tok_q[rd_ptr_q].kind;
  assign m_axis_tlast  = q_last_q[rd_ptr_q];
  assign m_axis_tdata  = {4'd0, q_tok_q[rd_ptr_q].ovf, q_tok_q[rd_ptr_q].err,
                          q_tok_q[rd_ptr_q].value};

endmodule

// File: verif/lisp_atom_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// lisp_atom_lexer_core_tb: self-checking bench for the Scheme atom lexer
// Streams directed and randomly built source text into the lexer, predicts
// every token in the bench and checks each one at the output, with random
// gaps on the byte side and random stalls on the token side.
// ----------------------------------------------------------------------------
module lisp_atom_lexer_core_tb;
  import lal_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  typedef struct {
    tok_kind_e   kind;
    logic [63:0] value;
    err_code_e   err;
    logic        ovf;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;  // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // [63:0] value, [66:64] error, [67] overflow
  logic [2:0]  m_axis_tuser;         // token_kind
  logic        m_axis_tlast;         // last_in_run

  lisp_atom_lexer_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  src_byte_t   src_q[$];
  token_t      tokens_due[$];
  token_t      step_toks[$];
  int unsigned n_fail = 0;
  int unsigned n_bytes = 0;
  int unsigned n_tokens = 0;
  bit          no_idle = 1'b0;

  // Lexer shadow context
  lex_state_e  sh_st;
  logic [63:0] sh_acc;
  logic        sh_neg;
  logic [7:0]  sh_held;
  logic [2:0]  sh_nsel;
  logic [2:0]  sh_npos;
  logic        sh_sat;

  string       char_names [6] = '{"nul", "newline", "tab", "linefeed", "return", "space"};
  logic [7:0]  name_codes [6] = '{8'd0, 8'd10, 8'd9, 8'd10, 8'd13, 8'd32};

  function automatic bit is_ws(logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_delim(logic [7:0] b, bit eoi);
    return eoi || is_ws(b) || b == "(" || b == ")" || b == "\"" || b == CH_SEMI;
  endfunction

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void push_tok(tok_kind_e k, logic [63:0] v, err_code_e e, logic o);
    token_t t;
    if (step_toks.size() >= 3) return;
    t.kind = k; t.value = v; t.err = e; t.ovf = o; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void add_digit(logic [7:0] d);
    logic [63:0] lim;
    lim = sh_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (sh_acc > (lim - d) / 64'd10) begin
      sh_acc = lim;
      sh_sat = 1'b1;
    end else begin
      sh_acc = sh_acc * 64'd10 + d;
    end
  endfunction

  function automatic void start_fix(logic [7:0] d, logic neg);
    sh_neg = neg; sh_acc = '0; sh_sat = 1'b0;
    add_digit(d);
    sh_st = ST_FIX;
  endfunction

  function automatic int name_match(logic [7:0] c, logic [7:0] a);
    if (c == "n" && a == "u") return 0;
    if (c == "n" && a == "e") return 1;
    if (c == "t" && a == "a") return 2;
    if (c == "l" && a == "i") return 3;
    if (c == "r" && a == "e") return 4;
    if (c == "s" && a == "p") return 5;
    return -1;
  endfunction

  function automatic int esc_code(logic [7:0] e);
    case (e)
      "a": return 7;
      "b": return 8;
      "t": return 9;
      "n": return 10;
      "v": return 11;
      "f": return 12;
      "r": return 13;
      "\"": return 34;
      "\\": return 92;
      default: return -1;
    endcase
  endfunction

  // One pass of the lexer over a byte; returns 1 when the byte is handled again
  function automatic bit lex_pass(logic [7:0] b, bit eoi);
    logic [63:0] bv;
    int          k;
    int          sel;
    int          len;
    logic [7:0]  want;
    bv = eoi ? 64'd0 : {56'd0, b};
    case (sh_st)
      ST_IDLE: begin
        if (eoi) begin push_tok(K_END, 0, E_BAD_START, 0); return 0; end
        if (is_ws(b)) return 0;
        if (b == CH_SEMI) begin sh_st = ST_COMMENT; return 0; end
        if (is_dig(b)) begin start_fix(b - "0", 1'b0); return 0; end
        if (b == "+" || b == "-") begin sh_held = b; sh_st = ST_SIGN; return 0; end
        if (b == "#") begin sh_st = ST_HASH; return 0; end
        if (b == "\"") begin sh_st = ST_STR; return 0; end
        push_tok(K_ERR, bv, E_BAD_START, 0);
        return 0;
      end
      ST_COMMENT: begin
        if (eoi) begin sh_st = ST_IDLE; return 1; end
        if (b == 8'h0A) sh_st = ST_IDLE;
        return 0;
      end
      ST_SIGN: begin
        if (!eoi && is_dig(b)) begin start_fix(b - "0", sh_held == "-"); return 0; end
        push_tok(K_ERR, {56'd0, sh_held}, E_BAD_START, 0);
        sh_st = ST_IDLE;
        return 1;
      end
      ST_FIX: begin
        if (!eoi && is_dig(b)) begin add_digit(b - "0"); return 0; end
        if (is_delim(b, eoi))
          push_tok(K_FIX, sh_neg ? 64'd0 - sh_acc : sh_acc, E_BAD_START, sh_sat);
        else
          push_tok(K_ERR, bv, E_FIX_DELIM, 0);
        sh_st = ST_IDLE;
        return 1;
      end
      ST_HASH: begin
        if (!eoi && b == "\\") begin sh_st = ST_CHAR0; return 0; end
        if (!eoi && (b == "t" || b == "f")) begin sh_held = b; sh_st = ST_BOOL; return 0; end
        push_tok(K_ERR, bv, E_BAD_BOOL, 0);
        sh_st = ST_IDLE;
        return eoi;
      end
      ST_BOOL: begin
        if (is_delim(b, eoi)) push_tok(K_BOOL, {63'd0, sh_held == "t"}, E_BAD_START, 0);
        else push_tok(K_ERR, bv, E_BAD_BOOL, 0);
        sh_st = ST_IDLE;
        return 1;
      end
      ST_CHAR0: begin
        if (eoi) begin push_tok(K_ERR, 0, E_CHAR_END, 0); sh_st = ST_IDLE; return 1; end
        if (is_ws(b)) begin push_tok(K_ERR, bv, E_SPACE_CHAR, 0); sh_st = ST_IDLE; return 0; end
        sh_held = b;
        sh_st = ST_CHAR1;
        return 0;
      end
      ST_CHAR1: begin
        if (is_delim(b, eoi)) begin
          push_tok(K_CHAR, {56'd0, sh_held}, E_BAD_START, 0);
          sh_st = ST_IDLE;
          return 1;
        end
        k = name_match(sh_held, b);
        if (k >= 0) begin
          sh_nsel = k[2:0];
          sh_npos = 3'(char_names[k].len() - 2);
          sh_st = ST_NAME;
          return 0;
        end
        push_tok(K_ERR, bv, E_BAD_CHAR, 0);
        sh_st = ST_IDLE;
        return 1;
      end
      ST_NAME: begin
        sel = sh_nsel < 6 ? sh_nsel : 0;
        len = char_names[sel].len();
        if (sh_npos > len - 2) sh_npos = 3'(len - 2);
        if (sh_npos > 0) begin
          want = char_names[sel][(len - sh_npos) & 7];
          if (!eoi && b == want) begin sh_npos = sh_npos - 3'd1; return 0; end
          push_tok(K_ERR, bv, E_BAD_CHAR, 0);
        end else if (is_delim(b, eoi)) begin
          push_tok(K_CHAR, {56'd0, name_codes[sel]}, E_BAD_START, 0);
        end else begin
          push_tok(K_ERR, bv, E_BAD_CHAR, 0);
        end
        sh_st = ST_IDLE;
        return 1;
      end
      ST_STR: begin
        if (eoi) begin push_tok(K_ERR, 0, E_STR_END, 0); sh_st = ST_IDLE; return 1; end
        if (b == "\"") begin push_tok(K_SEND, 0, E_BAD_START, 0); sh_st = ST_IDLE; return 0; end
        if (b == "\\") begin sh_st = ST_ESC; return 0; end
        push_tok(K_SCHAR, bv, E_BAD_START, 0);
        return 0;
      end
      ST_ESC: begin
        if (eoi) begin push_tok(K_ERR, 0, E_BAD_ESC, 0); sh_st = ST_IDLE; return 1; end
        k = esc_code(b);
        if (k >= 0) begin
          push_tok(K_SCHAR, 64'(k), E_BAD_START, 0);
          sh_st = ST_STR;
          return 0;
        end
        if (b == 8'h0A) begin sh_st = ST_CONT2; return 0; end
        if (is_ws(b)) begin sh_st = ST_CONT1; return 0; end
        push_tok(K_ERR, bv, E_BAD_ESC, 0);
        sh_st = ST_IDLE;
        return 0;
      end
      ST_CONT1: begin
        if (eoi) begin push_tok(K_ERR, 0, E_BAD_ESC, 0); sh_st = ST_IDLE; return 1; end
        if (b == 8'h0A) begin sh_st = ST_CONT2; return 0; end
        if (is_ws(b)) return 0;
        push_tok(K_ERR, bv, E_BAD_ESC, 0);
        sh_st = ST_IDLE;
        return 0;
      end
      ST_CONT2: begin
        if (!eoi && is_ws(b) && b != 8'h0A) return 0;
        sh_st = ST_STR;
        return 1;
      end
      default: begin
        sh_st = ST_IDLE;
        return 1;
      end
    endcase
  endfunction

  // Predict the tokens of one accepted byte and queue them
  function automatic void predict_tokens(src_byte_t sb);
    bit again;
    again = 1'b1;
    step_toks.delete();
    for (int i = 0; i < 4 && again; i++) again = lex_pass(sb.ch, sb.eoi);
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  function automatic void put_text(string s);
    src_byte_t sb;
    for (int i = 0; i < s.len(); i++) begin
      sb.ch = s[i]; sb.eoi = 1'b0;
      src_q.push_back(sb);
    end
  endfunction

  function automatic void put_byte(logic [7:0] b);
    src_byte_t sb;
    sb.ch = b; sb.eoi = 1'b0;
    src_q.push_back(sb);
  endfunction

  function automatic void put_eoi();
    src_byte_t sb;
    sb.ch = 8'($urandom); sb.eoi = 1'b1;
    src_q.push_back(sb);
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0] d [8] = '{8'h20, "(", ")", "\"", CH_SEMI, 8'h09, 8'h0A, 8'h0D};
    return d[$urandom_range(0, 7)];
  endfunction

  // Delimiter most of the time, otherwise any byte or end of input
  function automatic void put_follow();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) put_byte(pick_delim());
    else if (r < 9) put_byte(8'($urandom));
    else put_eoi();
  endfunction

  // One random source fragment, mostly well formed
  function automatic void put_fragment();
    int         r;
    int         n;
    string      nm;
    logic [7:0] c;
    string      esc = "abtnvfr\"\\q";
    r = $urandom_range(0, 19);
    if (r < 5) begin
      r = $urandom_range(0, 2);
      if (r == 1) put_byte("-");
      else if (r == 2) put_byte("+");
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
      put_follow();
    end else if (r < 7) begin
      put_byte("#");
      put_byte($urandom_range(0, 7) == 0 ? 8'($urandom) : ($urandom_range(0, 1) ? "t" : "f"));
      put_follow();
    end else if (r < 11) begin
      put_text("#\\");
      if ($urandom_range(0, 1)) begin
        put_byte(8'($urandom_range(33, 126)));
      end else begin
        nm = char_names[$urandom_range(0, 5)];
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nm.len()) : nm.len();
        for (int i = 0; i < n; i++) put_byte(nm[i]);
        if ($urandom_range(0, 5) == 0) put_byte(8'($urandom_range(97, 122)));
      end
      put_follow();
    end else if (r < 15) begin
      put_byte("\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          // printable text, keeping quote and backslash out of plain characters
          c = 8'($urandom_range(32, 126));
          put_byte((c == "\\" || c == "\"") ? "x" : c);
        end else if (r < 8) begin
          put_byte("\\");
          put_byte(esc[$urandom_range(0, esc.len() - 1)]);
        end else if (r < 9) begin
          put_byte("\\");
          if ($urandom_range(0, 1)) put_byte(8'h20);
          put_byte(8'h0A);
          put_byte(8'h20);
        end else begin
          put_byte(8'($urandom_range(128, 255)));
        end
      end
      if ($urandom_range(0, 7) == 0) put_eoi();
      else put_byte("\"");
    end else if (r < 16) begin
      put_text(";x");
      put_byte(8'($urandom));
      put_byte(8'h0A);
    end else if (r < 19) begin
      put_byte(8'($urandom));
    end else begin
      put_eoi();
    end
  endfunction

  // Byte driver: per-request gap, holds data while stalled
  int unsigned src_gap = 0;
  src_byte_t   cur_src;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tokens(cur_src);
        n_bytes++;
        if (n_bytes % 64 == 0) no_idle = ~no_idle;
        src_gap = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the pending request
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (src_q.size() > 0) begin
        cur_src = src_q.pop_front();
        s_axis_tdata  <= cur_src.ch;
        s_axis_tlast  <= cur_src.eoi;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Token monitor: random stalls, compares against the oldest prediction
  int unsigned sink_stall = 0;
  token_t      exp_tok;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_tokens++;
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token kind %0d value %h", $time,
                   m_axis_tuser, m_axis_tdata[63:0]);
          n_fail++;
        end else begin
          exp_tok = tokens_due.pop_front();
          if (m_axis_tuser !== exp_tok.kind || m_axis_tdata[63:0] !== exp_tok.value ||
              m_axis_tdata[66:64] !== exp_tok.err || m_axis_tdata[67] !== exp_tok.ovf ||
              m_axis_tlast !== exp_tok.last) begin
            $display("%0t: token mismatch expected kind %0d value %h err %0d ovf %b last %b",
                     $time, exp_tok.kind, exp_tok.value, exp_tok.err, exp_tok.ovf,
                     exp_tok.last);
            $display("%0t:                actual kind %0d value %h err %0d ovf %b last %b",
                     $time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[66:64],
                     m_axis_tdata[67], m_axis_tlast);
            n_fail++;
          end
        end
        sink_stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    // Directed: extremes and the special cases
    put_text("9223372036854775807 -9223372036854775808 99999999999999999999)");
    put_text("+x 12a #t #fz #q #\\space #\\newline; #\\nx #\\ #\\");
    put_eoi();
    put_text("\"a\\n\\q #\\tab");
    put_eoi();
    put_text("-");
    put_eoi();
    put_byte(8'hFF);
    put_byte(8'h00);
    put_text(";note\n\"\\ \n x\\");
    put_eoi();
    put_text("\"\\  z");
    put_eoi();
    // continuation still open at end of input
    put_text("\"ab\\\n ");
    put_eoi();
    // Random fragments
    while (src_q.size() < 500) put_fragment();
    put_eoi();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (src_q.size() == 0 && !s_axis_tvalid && tokens_due.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Lexed %0d bytes into %0d tokens: fixnums with overflow, booleans,", n_bytes,
             n_tokens);
    $display("character names, string escapes and continuations, errors and end of input.");
    if (n_fail == 0 && tokens_due.size() == 0) begin
      $display("lisp_atom_lexer_core regression: pass");
    end else begin
      $display("lisp_atom_lexer_core regression: fail");
    end
    $finish;
  end

  initial begin
    sh_st = ST_IDLE; sh_acc = '0; sh_neg = 0; sh_held = '0;
    sh_nsel = '0; sh_npos = '0; sh_sat = 0;
    #20000000;
    $display("lisp_atom_lexer_core regression: fail");
    $finish;
  end

endmodule
